### hdl/ssr_pkg.sv
package ssr_pkg;

    localparam int WORD_W    = 64;
    localparam int BIT_W     = 6;
    localparam int IDX_W     = 5;
    localparam int CAP_W     = 11;
    localparam int WEIGHT_W  = 16;
    localparam int MAX_WORDS = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DRAIN,
        ST_READ,
        ST_FLUSH
    } state_t;

    // Value of a bitmap word that has not been written since the last clear.
    function automatic logic [WORD_W-1:0] init_word(input logic is_word0);
        init_word = {{(WORD_W-1){1'b0}}, is_word0};
    endfunction

endpackage

### hdl/ssr_ram.sv
module ssr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

### hdl/ssr_shifter.sv
module ssr_shifter (
    input  logic [ssr_pkg::WORD_W-1:0] base,
    input  logic [ssr_pkg::WORD_W-1:0] hi,
    input  logic [ssr_pkg::WORD_W-1:0] lo,
    input  logic [ssr_pkg::BIT_W-1:0]  bs,
    output logic [ssr_pkg::WORD_W-1:0] merged
);

    import ssr_pkg::*;

    logic [2*WORD_W-1:0] funnel;

    // The upper half of the shifted pair is hi << bs with the top of lo carried in.
    always_comb
    begin
        funnel = {hi, lo} << bs;
        merged = base | funnel[2*WORD_W-1:WORD_W];
    end

endmodule

### hdl/subset_sum_reachability.sv
// Channel   Ports                                   Handshake
// --------  --------------------------------------  ------------------------------
// item in   weight, last_weight                     start high while busy is low
// result    word_index, reach_bits, last_word       result_valid, one cycle each
// config    capacity                                cfg_write, taken at once
//
// A weight from 1 to the capacity occupies the block with an update pass: the bitmap words
// pass one a cycle through the single shift-and-OR unit, highest first, after a priming
// read of the source and followed by a drain state that retires the last write. Any other
// weight skips the update. A last item then adds a readout of words 0 to top, where top
// is the capacity divided by 64, after which the bitmap is cleared in the flush state.
// Reset leaves the bitmap holding sum zero only; results cannot be stalled.
module subset_sum_reachability #(
    parameter int MAP_BITS = 2048
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ssr_pkg::WEIGHT_W-1:0]  weight,
    input  logic                          last_weight,
    input  logic                          cfg_write,
    input  logic [ssr_pkg::CAP_W-1:0]     capacity,
    output logic                          result_valid,
    output logic [ssr_pkg::IDX_W-1:0]     word_index,
    output logic [ssr_pkg::WORD_W-1:0]    reach_bits,
    output logic                          last_word
);

    import ssr_pkg::*;

    // Sums above 2047 can never be read out, so at most 32 words are stored.
    localparam int MAP_WORDS = (MAP_BITS / 64 > MAX_WORDS) ? MAX_WORDS : MAP_BITS / 64;
    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int DW = $clog2(MAP_WORDS + 1);
    localparam int SW = 7;
    localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(MAP_WORDS * 64 - 1);

    state_t state_reg, state_next;

    logic [DW-1:0]        d_reg, d_next;
    logic [AW-1:0]        k_reg, k_next;
    logic [IDX_W-1:0]     ws_reg, ws_next;
    logic [BIT_W-1:0]     bs_reg, bs_next;
    logic [CAP_W-1:0]     cap_reg, cap_next;
    logic                 last_reg, last_next;
    logic [CAP_W-1:0]     capacity_reg;

    logic                 stg_act_reg;
    logic                 stg_wr_reg;
    logic                 stg_src_ok_reg;
    logic [AW-1:0]        stg_addr_reg;
    logic [WORD_W-1:0]    hi_reg;
    logic [MAP_WORDS-1:0] valid_reg;
    logic                 va_reg, vb_reg, za_reg, zb_reg;
    logic                 rd_act_reg, rd_last_reg;
    logic [AW-1:0]        rd_idx_reg;

    logic                 result_valid_reg;
    logic [IDX_W-1:0]     word_index_reg;
    logic [WORD_W-1:0]    reach_bits_reg;
    logic                 last_word_reg;

    logic [CAP_W-1:0]     cap_eff;
    logic                 do_update;
    logic                 clear_all;
    logic [SW-1:0]        src;
    logic                 src_neg;
    logic [AW-1:0]        addr_a, addr_b;
    logic [WORD_W-1:0]    rdata_a, rdata_b;
    logic [WORD_W-1:0]    a_word, b_word, lo_word, new_word;
    logic [WORD_W-1:0]    top_mask;
    logic [IDX_W-1:0]     top_idx;

    assign cap_eff   = (capacity_reg > CAP_MAX) ? CAP_MAX : capacity_reg;
    assign do_update = (weight != '0) && (weight <= WEIGHT_W'(cap_eff));
    assign top_idx   = cap_reg[CAP_W-1:BIT_W];

    // Source for destination word d is d - ws - 1; its neighbour d - ws arrived in the previous cycle.
    assign src     = SW'(d_reg) - SW'(ws_reg) - SW'(1);
    assign src_neg = src[SW-1];
    assign addr_b  = src_neg ? '0 : src[AW-1:0];

    always_comb
    begin
        case (state_reg)
            ST_UPDATE: addr_a = (d_reg == DW'(MAP_WORDS)) ? '0 : d_reg[AW-1:0];
            ST_READ:   addr_a = k_reg;
            default:   addr_a = '0;
        endcase
    end

    assign a_word  = va_reg ? rdata_a : init_word(za_reg);
    assign b_word  = vb_reg ? rdata_b : init_word(zb_reg);
    assign lo_word = stg_src_ok_reg ? b_word : '0;

    always_comb
    begin
        for (int i = 0; i < WORD_W; i++)
        begin
            top_mask[i] = (BIT_W'(i) <= cap_reg[BIT_W-1:0]);
        end
    end

    ssr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk     (clk),
        .we      (stg_wr_reg),
        .waddr   (stg_addr_reg),
        .wdata   (new_word),
        .raddr_a (addr_a),
        .rdata_a (rdata_a),
        .raddr_b (addr_b),
        .rdata_b (rdata_b)
    );

    ssr_shifter u_shift (
        .base   (a_word),
        .hi     (hi_reg),
        .lo     (lo_word),
        .bs     (bs_reg),
        .merged (new_word)
    );

    always_comb
    begin
        state_next = state_reg;
        d_next     = d_reg;
        k_next     = k_reg;
        ws_next    = ws_reg;
        bs_next    = bs_reg;
        cap_next   = cap_reg;
        last_next  = last_reg;
        clear_all  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cap_next  = cap_eff;
                    last_next = last_weight;
                    ws_next   = weight[BIT_W+IDX_W-1:BIT_W];
                    bs_next   = weight[BIT_W-1:0];
                    d_next    = DW'(MAP_WORDS);
                    k_next    = '0;
                    if (do_update)
                    begin
                        state_next = ST_UPDATE;
                    end
                    else if (last_weight)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_UPDATE:
            begin
                d_next = d_reg - DW'(1);
                if (d_reg == '0)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                k_next     = '0;
                state_next = last_reg ? ST_READ : ST_IDLE;
            end
            ST_READ:
            begin
                k_next = k_reg + AW'(1);
                if (IDX_W'(k_reg) == top_idx)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                clear_all  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            capacity_reg     <= '1;
            valid_reg        <= '0;
            stg_act_reg      <= 1'b0;
            stg_wr_reg       <= 1'b0;
            rd_act_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            stg_act_reg      <= (state_reg == ST_UPDATE);
            stg_wr_reg       <= (state_reg == ST_UPDATE) && (d_reg != DW'(MAP_WORDS));
            rd_act_reg       <= (state_reg == ST_READ);
            result_valid_reg <= rd_act_reg;
            if (cfg_write)
            begin
                capacity_reg <= capacity;
            end
            if (clear_all)
            begin
                valid_reg <= '0;
            end
            else if (stg_wr_reg)
            begin
                valid_reg[stg_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg          <= d_next;
        k_reg          <= k_next;
        ws_reg         <= ws_next;
        bs_reg         <= bs_next;
        cap_reg        <= cap_next;
        last_reg       <= last_next;
        stg_addr_reg   <= addr_a;
        stg_src_ok_reg <= !src_neg;
        va_reg         <= valid_reg[addr_a];
        vb_reg         <= valid_reg[addr_b];
        za_reg         <= (addr_a == '0);
        zb_reg         <= (addr_b == '0);
        rd_idx_reg     <= k_reg;
        rd_last_reg    <= (IDX_W'(k_reg) == top_idx);
        if (stg_act_reg)
        begin
            hi_reg <= lo_word;
        end
        if (rd_act_reg)
        begin
            word_index_reg <= IDX_W'(rd_idx_reg);
            reach_bits_reg <= rd_last_reg ? (a_word & top_mask) : a_word;
            last_word_reg  <= rd_last_reg;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign word_index   = word_index_reg;
    assign reach_bits   = reach_bits_reg;
    assign last_word    = last_word_reg;

endmodule
